// ===== rtl/olde_pkg.sv =====
// Shared types, codes and the control store of the ordered list engine.
package olde_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int STEP_W = 5;

  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_REM_MATCH = 3'd2;
  localparam logic [2:0] OP_REM_BACK  = 3'd3;
  localparam logic [2:0] OP_REM_FRONT = 3'd4;
  localparam logic [2:0] OP_LENGTH    = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
  localparam logic [2:0] ACT_DEC_COUNT  = 3'd4;
  localparam logic [2:0] ACT_CLR_SCAN   = 3'd5;
  localparam logic [2:0] ACT_SCAN       = 3'd6;

  localparam logic [2:0] COND_NEVER = 3'd0;
  localparam logic [2:0] COND_FULL  = 3'd1;
  localparam logic [2:0] COND_EMPTY = 3'd2;
  localparam logic [2:0] COND_MORE  = 3'd3;
  localparam logic [2:0] COND_FOUND = 3'd4;

  localparam logic [STEP_W-1:0] S_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] S_IF_CHK    = 5'd1;
  localparam logic [STEP_W-1:0] S_IF_DO     = 5'd2;
  localparam logic [STEP_W-1:0] S_IB_CHK    = 5'd3;
  localparam logic [STEP_W-1:0] S_IB_DO     = 5'd4;
  localparam logic [STEP_W-1:0] S_RM_CHK    = 5'd5;
  localparam logic [STEP_W-1:0] S_RM_SCAN   = 5'd6;
  localparam logic [STEP_W-1:0] S_RM_TEST   = 5'd7;
  localparam logic [STEP_W-1:0] S_RM_MISS   = 5'd8;
  localparam logic [STEP_W-1:0] S_RM_DO     = 5'd9;
  localparam logic [STEP_W-1:0] S_RB_CHK    = 5'd10;
  localparam logic [STEP_W-1:0] S_RB_DO     = 5'd11;
  localparam logic [STEP_W-1:0] S_RF_CHK    = 5'd12;
  localparam logic [STEP_W-1:0] S_RF_DO     = 5'd13;
  localparam logic [STEP_W-1:0] S_LEN       = 5'd14;
  localparam logic [STEP_W-1:0] S_REFUSE    = 5'd15;
  localparam logic [STEP_W-1:0] S_EMPTY_ERR = 5'd16;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] list_length;
  } result_t;

  typedef struct packed {
    logic [2:0] act;
    logic       emit;
    logic [1:0] status;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    dp_ctl_t           ctl;
  } uword_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic more;
    logic found;
  } dp_flags_t;

  function automatic uword_t mk(input logic [2:0] cond, input logic [STEP_W-1:0] target,
                                input logic [2:0] act, input logic emit,
                                input logic [1:0] status);
    uword_t w;
    w.cond       = cond;
    w.target     = target;
    w.ctl.act    = act;
    w.ctl.emit   = emit;
    w.ctl.status = status;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      S_IF_CHK:    w = mk(COND_FULL,  S_REFUSE,    ACT_NONE,       1'b0, ST_DONE);
      S_IF_DO:     w = mk(COND_NEVER, S_IDLE,      ACT_PUSH_FRONT, 1'b1, ST_DONE);
      S_IB_CHK:    w = mk(COND_FULL,  S_REFUSE,    ACT_NONE,       1'b0, ST_DONE);
      S_IB_DO:     w = mk(COND_NEVER, S_IDLE,      ACT_PUSH_BACK,  1'b1, ST_DONE);
      S_RM_CHK:    w = mk(COND_EMPTY, S_EMPTY_ERR, ACT_CLR_SCAN,   1'b0, ST_DONE);
      S_RM_SCAN:   w = mk(COND_MORE,  S_RM_SCAN,   ACT_SCAN,       1'b0, ST_DONE);
      S_RM_TEST:   w = mk(COND_FOUND, S_RM_DO,     ACT_NONE,       1'b0, ST_DONE);
      S_RM_MISS:   w = mk(COND_NEVER, S_IDLE,      ACT_NONE,       1'b1, ST_NOTFOUND);
      S_RM_DO:     w = mk(COND_NEVER, S_IDLE,      ACT_DEC_COUNT,  1'b1, ST_DONE);
      S_RB_CHK:    w = mk(COND_EMPTY, S_EMPTY_ERR, ACT_NONE,       1'b0, ST_DONE);
      S_RB_DO:     w = mk(COND_NEVER, S_IDLE,      ACT_DEC_COUNT,  1'b1, ST_DONE);
      S_RF_CHK:    w = mk(COND_EMPTY, S_EMPTY_ERR, ACT_NONE,       1'b0, ST_DONE);
      S_RF_DO:     w = mk(COND_NEVER, S_IDLE,      ACT_POP_FRONT,  1'b1, ST_DONE);
      S_LEN:       w = mk(COND_NEVER, S_IDLE,      ACT_NONE,       1'b1, ST_DONE);
      S_REFUSE:    w = mk(COND_NEVER, S_IDLE,      ACT_NONE,       1'b1, ST_FULL);
      S_EMPTY_ERR: w = mk(COND_NEVER, S_IDLE,      ACT_NONE,       1'b1, ST_EMPTY);
      default:     w = mk(COND_NEVER, S_IDLE,      ACT_NONE,       1'b0, ST_DONE);
    endcase
    return w;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch(input logic [2:0] op);
    logic [STEP_W-1:0] s;
    unique case (op)
      OP_INS_FRONT: s = S_IF_CHK;
      OP_INS_BACK:  s = S_IB_CHK;
      OP_REM_MATCH: s = S_RM_CHK;
      OP_REM_BACK:  s = S_RB_CHK;
      OP_REM_FRONT: s = S_RF_CHK;
      default:      s = S_LEN;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/olde_sequencer.sv =====
// Step counter and conditional branching over the control store.
module olde_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [2:0]                          op,
  input  olde_pkg::dp_flags_t                 flags,
  output logic                                busy,
  output olde_pkg::dp_ctl_t                   ctl
);

  logic [olde_pkg::STEP_W-1:0] step;
  logic [olde_pkg::STEP_W-1:0] step_next;
  olde_pkg::uword_t            word;
  logic                        take;

  always_comb begin
    word = olde_pkg::ucode(step);
    ctl  = word.ctl;
    busy = (step != olde_pkg::S_IDLE);
    unique case (word.cond)
      olde_pkg::COND_FULL:  take = flags.full;
      olde_pkg::COND_EMPTY: take = flags.empty;
      olde_pkg::COND_MORE:  take = flags.more;
      olde_pkg::COND_FOUND: take = flags.found;
      default:              take = 1'b0;
    endcase
    priority if (step == olde_pkg::S_IDLE) begin
      step_next = start ? olde_pkg::dispatch(op) : olde_pkg::S_IDLE;
    end else if (word.ctl.emit) begin
      step_next = olde_pkg::S_IDLE;
    end else if (take) begin
      step_next = word.target;
    end else begin
      step_next = step + olde_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= olde_pkg::S_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/olde_datapath.sv =====
// Slot storage, list pointers, scan registers and the result register.
module olde_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic signed [31:0]          value,
  input  olde_pkg::dp_ctl_t           ctl,
  output olde_pkg::dp_flags_t         flags,
  output logic                        done,
  output olde_pkg::result_t           result
);

  logic signed [31:0]           ent [olde_pkg::DEPTH];
  logic signed [31:0]           val_r;
  logic [olde_pkg::SLOT_W-1:0]  first_slot;
  logic [olde_pkg::SLOT_W-1:0]  first_slot_next;
  logic [olde_pkg::CNT_W-1:0]   count;
  logic [olde_pkg::CNT_W-1:0]   count_next;
  logic [olde_pkg::CNT_W-1:0]   pos;
  logic [olde_pkg::CNT_W-1:0]   pos_next;
  logic                         found;
  logic                         found_next;
  logic [olde_pkg::SLOT_W-1:0]  rd_slot;
  logic signed [31:0]           rd_data;
  logic                         we;
  logic [olde_pkg::SLOT_W-1:0]  waddr;
  logic signed [31:0]           wdata;

  always_comb begin
    rd_slot         = first_slot + pos[olde_pkg::SLOT_W-1:0];
    rd_data         = ent[rd_slot];
    flags.full      = (count == olde_pkg::CNT_W'(olde_pkg::DEPTH));
    flags.empty     = (count == '0);
    flags.more      = ((pos + olde_pkg::CNT_W'(1)) != count);
    flags.found     = found;
    first_slot_next = first_slot;
    count_next      = count;
    pos_next        = pos;
    found_next      = found;
    we              = 1'b0;
    waddr           = rd_slot - olde_pkg::SLOT_W'(1);
    wdata           = val_r;
    unique case (ctl.act)
      olde_pkg::ACT_PUSH_FRONT: begin
        first_slot_next = first_slot - olde_pkg::SLOT_W'(1);
        count_next      = count + olde_pkg::CNT_W'(1);
        we              = 1'b1;
        waddr           = first_slot - olde_pkg::SLOT_W'(1);
      end
      olde_pkg::ACT_PUSH_BACK: begin
        count_next = count + olde_pkg::CNT_W'(1);
        we         = 1'b1;
        waddr      = first_slot + count[olde_pkg::SLOT_W-1:0];
      end
      olde_pkg::ACT_POP_FRONT: begin
        first_slot_next = first_slot + olde_pkg::SLOT_W'(1);
        count_next      = count - olde_pkg::CNT_W'(1);
      end
      olde_pkg::ACT_DEC_COUNT: begin
        count_next = count - olde_pkg::CNT_W'(1);
      end
      olde_pkg::ACT_CLR_SCAN: begin
        pos_next   = '0;
        found_next = 1'b0;
      end
      olde_pkg::ACT_SCAN: begin
        // Once the match is seen, each later entry moves one slot toward the front.
        we         = found;
        wdata      = rd_data;
        found_next = found | (rd_data == val_r);
        pos_next   = pos + olde_pkg::CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ent[waddr] <= wdata;
    end
    if (load) begin
      val_r <= value;
    end
    pos                <= pos_next;
    found              <= found_next;
    result.status      <= ctl.status;
    result.list_length <= count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_slot <= '0;
      count      <= '0;
      done       <= 1'b0;
    end else begin
      first_slot <= first_slot_next;
      count      <= count_next;
      done       <= ctl.emit;
    end
  end

endmodule

// ===== rtl/ordered_list_deque_engine_unit.sv =====
// Top level of the ordered list engine: control sequencer and list datapath.
// The scan of remove by value visits one stored entry per cycle through the single read port.
// A new transfer is taken in the cycle the done strobe is shown; results cannot be stalled.
// Synchronous reset empties the list; slot contents stay undefined until written.
module ordered_list_deque_engine_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  olde_pkg::item_t     item,
  output logic                busy,
  output logic                done,
  output olde_pkg::result_t   result
);

  olde_pkg::dp_ctl_t   ctl;
  olde_pkg::dp_flags_t flags;
  logic                load;

  assign load = start & ~busy;

  olde_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .flags (flags),
    .busy  (busy),
    .ctl   (ctl)
  );

  olde_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .value  (item.value),
    .ctl    (ctl),
    .flags  (flags),
    .done   (done),
    .result (result)
  );

endmodule
